@@ design/spfds_pkg.sv @@
// spfds_pkg: shared widths, constants, state and command types for the
// smallest-prime-factor sieve / divisor-sum block. No dependencies.
package spfds_pkg;

  // payload widths
  localparam int NUM_W  = 10;
  localparam int SUM_W  = 12;
  localparam int TERM_W = NUM_W + 1;          // 1 + p + ... + p^e < 2 * p^e
  localparam int ACC_W  = SUM_W + 1;          // running product, saturates one above max
  localparam int PROD_W = ACC_W + TERM_W;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // at most nine factor results before the final one
  localparam int MAX_FACTORS = 9;
  localparam int CNT_W       = 4;

  // divider retires two quotient bits per cycle
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // table read address source
  typedef enum logic [1:0] {
    RD_IDX,
    RD_P,
    RD_N
  } spfds_rd_e;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_P_TEST,
    ST_P_CHK,
    ST_M_RD,
    ST_M_WR,
    ST_IDLE,
    ST_Q_TEST,
    ST_Q_CHK,
    ST_Q_DIV,
    ST_Q_FIN
  } spfds_state_e;

  // controller to datapath
  typedef struct packed {
    logic      fill;      // write initial entry at idx, advance idx
    logic      p_next;    // advance sieve prime candidate
    logic      m_init;    // idx <= p * p
    logic      m_next;    // idx <= idx + p
    logic      mark;      // write p at idx
    spfds_rd_e rd_sel;
    logic      q_load;    // take a new query
    logic      q_factor;  // emit factor, update sum terms, start divider
    logic      q_quot;    // n <= n / p
    logic      q_final;   // emit final result
  } spfds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic pp_done;
    logic p_prime;
    logic idx_done;
    logic idx_hit;
    logic in_range;
    logic n_gt1;
    logic cnt_full;
    logic rd_ge2;
    logic div_done;
    logic out_free;
  } spfds_sts_t;

endpackage

@@ design/spfds_if.sv @@
// spfds_in_if / spfds_out_if: valid/ready channels of the sieve block.
// Depends on spfds_pkg for payload widths.
interface spfds_in_if
  import spfds_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface spfds_out_if
  import spfds_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] prime_factor;
  logic [SUM_W-1:0] divisor_sum;
  logic             is_last;

  modport source (output valid, output prime_factor, output divisor_sum, output is_last,
                  input ready);
  modport sink   (input valid, input prime_factor, input divisor_sum, input is_last,
                  output ready);
endinterface

@@ design/spfds_div.sv @@
// spfds_div: iterative unsigned restoring divider, two quotient bits a cycle.
// Depends on spfds_pkg.
module spfds_div
  import spfds_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [NUM_W-1:0] divisor_i,
  output logic [NUM_W-1:0] quotient_o,
  output logic             done_o
);

  logic [NUM_W:0]    rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [NUM_W-1:0]  dvs_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  // two restoring steps per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_d = {rem_d[NUM_W-1:0], quo_d[NUM_W-1]};
      quo_d = {quo_d[NUM_W-2:0], 1'b0};
      if (rem_d >= {1'b0, dvs_q}) begin
        rem_d    = rem_d - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CW'(1);
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ design/spfds_ctrl.sv @@
// spfds_ctrl: sequencer for table sieve after reset and for query factoring.
// Depends on spfds_pkg; drives spfds_dpath through command/status structs.
module spfds_ctrl
  import spfds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  spfds_sts_t sts_i,
  output spfds_cmd_t cmd_o
);

  spfds_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RD_IDX;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = ST_P_TEST;
      end
      ST_P_TEST: begin
        cmd_o.rd_sel = RD_P;
        if (sts_i.pp_done) state_d = ST_IDLE;
        else               state_d = ST_P_CHK;
      end
      ST_P_CHK: begin
        if (sts_i.p_prime) begin
          cmd_o.m_init = 1'b1;
          state_d      = ST_M_RD;
        end else begin
          cmd_o.p_next = 1'b1;
          state_d      = ST_P_TEST;
        end
      end
      ST_M_RD: begin
        cmd_o.rd_sel = RD_IDX;
        if (sts_i.idx_done) begin
          cmd_o.p_next = 1'b1;
          state_d      = ST_P_TEST;
        end else begin
          state_d = ST_M_WR;
        end
      end
      ST_M_WR: begin
        // only entries still holding themselves take the new factor
        cmd_o.mark   = sts_i.idx_hit;
        cmd_o.m_next = 1'b1;
        state_d      = ST_M_RD;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.q_load = 1'b1;
          state_d      = ST_Q_TEST;
        end
      end
      ST_Q_TEST: begin
        cmd_o.rd_sel = RD_N;
        if (!sts_i.in_range || !sts_i.n_gt1 || sts_i.cnt_full) state_d = ST_Q_FIN;
        else                                                    state_d = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        cmd_o.rd_sel = RD_N;
        if (!sts_i.rd_ge2) begin
          state_d = ST_Q_FIN;
        end else if (sts_i.out_free) begin
          cmd_o.q_factor = 1'b1;
          state_d        = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.q_quot = 1'b1;
          state_d      = ST_Q_TEST;
        end
      end
      ST_Q_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.q_final = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

endmodule

@@ design/spfds_dpath.sv @@
// spfds_dpath: factor table memory, sieve counters, query registers, divisor-sum
// arithmetic and output register. Depends on spfds_pkg and spfds_div.
module spfds_dpath
  import spfds_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spfds_cmd_t       cmd_i,
  output spfds_sts_t       sts_o,
  input  logic [NUM_W-1:0] number_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [NUM_W-1:0] prime_factor_o,
  output logic [SUM_W-1:0] divisor_sum_o,
  output logic             is_last_o
);

  // only values a query can reach need entries
  localparam int DEPTH = (TABLE_SIZE < (1 << NUM_W)) ? TABLE_SIZE : (1 << NUM_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * AW;

  // table storage
  logic [NUM_W-1:0] mem_q [DEPTH];
  logic [NUM_W-1:0] rdata_q;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [NUM_W-1:0] wdata;
  logic             we;

  // sieve counters
  logic [AW:0]      idx_q;
  logic [AW-1:0]    p_q;
  logic [PW-1:0]    pp;
  logic [NUM_W-1:0] init_val;

  // query state
  logic [NUM_W-1:0]  n_q;
  logic              in_range_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ACC_W-1:0]  sum_q;
  logic [TERM_W-1:0] term_q;
  logic [NUM_W-1:0]  power_q;
  logic [NUM_W-1:0]  cur_q;

  // arithmetic
  logic [PROD_W-1:0]    prod;
  logic [2*NUM_W-1:0]   pw_prod;
  logic                 new_prime;
  logic [NUM_W-1:0]     power_nx;
  logic [SUM_W-1:0]     final_sum;
  logic [NUM_W-1:0]     quotient;
  logic                 div_done;

  // output register
  logic             out_valid_q;
  logic [NUM_W-1:0] pf_q;
  logic [SUM_W-1:0] ds_q;
  logic             last_q;
  logic             out_free;

  // sieve addressing
  assign pp       = PW'(p_q) * PW'(p_q);
  assign init_val = (idx_q >= (AW+1)'(2) && !idx_q[0]) ? NUM_W'(2) : NUM_W'(idx_q);

  assign we    = cmd_i.fill || cmd_i.mark;
  assign waddr = idx_q[AW-1:0];
  assign wdata = cmd_i.fill ? init_val : NUM_W'(p_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:  raddr = idx_q[AW-1:0];
      RD_P:    raddr = p_q;
      RD_N:    raddr = n_q[AW-1:0];
      default: raddr = idx_q[AW-1:0];
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // sieve counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      p_q   <= AW'(3);
    end else begin
      if (cmd_i.fill)        idx_q <= idx_q + (AW+1)'(1);
      else if (cmd_i.m_init) idx_q <= (AW+1)'(pp);
      else if (cmd_i.m_next) idx_q <= idx_q + (AW+1)'(p_q);
      if (cmd_i.p_next) p_q <= p_q + AW'(1);
    end
  end

  // divisor-sum arithmetic; one product feeds both the running and final sum
  assign prod      = PROD_W'(sum_q) * PROD_W'(term_q);
  assign pw_prod   = (2*NUM_W)'(power_q) * (2*NUM_W)'(rdata_q);
  assign new_prime = (rdata_q != cur_q);
  assign power_nx  = new_prime ? rdata_q : NUM_W'(pw_prod);
  assign final_sum = !in_range_q ? '0 :
                     (prod > PROD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(prod);

  // query registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.q_load) begin
      cnt_q <= '0;
    end else if (cmd_i.q_factor) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      n_q        <= number_i;
      in_range_q <= (32'(number_i) < TABLE_SIZE);
      sum_q      <= ACC_W'(1);
      term_q     <= TERM_W'(1);
      power_q    <= NUM_W'(1);
      cur_q      <= '0;
    end else if (cmd_i.q_factor) begin
      if (new_prime) begin
        sum_q  <= (prod > PROD_W'(SUM_MAX)) ? ACC_W'(SUM_MAX) + ACC_W'(1) : ACC_W'(prod);
        term_q <= TERM_W'(1) + TERM_W'(rdata_q);
      end else begin
        term_q <= term_q + TERM_W'(power_nx);
      end
      power_q <= power_nx;
      cur_q   <= rdata_q;
    end else if (cmd_i.q_quot) begin
      n_q <= quotient;
    end
  end

  // n / p, exact since p is the least factor of n
  spfds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.q_factor),
    .dividend_i (n_q),
    .divisor_i  (rdata_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // output register, refilled in the cycle the held result transfers
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.q_factor || cmd_i.q_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_factor) begin
      pf_q   <= rdata_q;
      ds_q   <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.q_final) begin
      pf_q   <= '0;
      ds_q   <= final_sum;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prime_factor_o = pf_q;
  assign divisor_sum_o  = ds_q;
  assign is_last_o      = last_q;

  // status
  assign sts_o.fill_last = (idx_q == (AW+1)'(DEPTH - 1));
  assign sts_o.pp_done   = (pp >= PW'(DEPTH));
  assign sts_o.p_prime   = (rdata_q == NUM_W'(p_q));
  assign sts_o.idx_done  = (idx_q >= (AW+1)'(DEPTH));
  assign sts_o.idx_hit   = (rdata_q == NUM_W'(idx_q));
  assign sts_o.in_range  = in_range_q;
  assign sts_o.n_gt1     = (n_q > NUM_W'(1));
  assign sts_o.cnt_full  = (cnt_q == CNT_W'(MAX_FACTORS));
  assign sts_o.rd_ge2    = (rdata_q >= NUM_W'(2));
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = out_free;

endmodule

@@ design/spf_sieve_divisor_sum.sv @@
// spf_sieve_divisor_sum: top level, joins controller and datapath to the
// valid/ready channels. Depends on spfds_pkg, spfds_if, spfds_ctrl, spfds_dpath.
//
// After reset the block builds its smallest-prime-factor table by a sieve and
// holds in_i.ready low until done: it fills the table, then marks the multiples
// of each sieve prime candidate that proves prime. A query then takes one
// number and returns its prime factors in ascending order with repetition,
// then a final transfer with is_last set that carries the sum of divisors
// (0 and 1 give a sum of 1; a number at or above TABLE_SIZE gives 0). Each
// factor takes a registered table read and a divider that retires two
// quotient bits per cycle; a query gives up to nine factors. One query is
// worked at a time; the result register lets the next query start while the
// last result still waits to be taken. The default TABLE_SIZE is 1024.
module spf_sieve_divisor_sum
  import spfds_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  spfds_in_if.sink    in_i,
  spfds_out_if.source out_o
);

  spfds_cmd_t cmd;
  spfds_sts_t sts;

  // sequencer
  spfds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, arithmetic and result register
  spfds_dpath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .number_i       (in_i.number),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .prime_factor_o (out_o.prime_factor),
    .divisor_sum_o  (out_o.divisor_sum),
    .is_last_o      (out_o.is_last)
  );

  // final result carries no factor
  a_last_no_factor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_last |-> out_o.prime_factor == '0)
    else $error("final result carries a prime factor");

  // factor results carry a real prime and no sum
  a_factor_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_last |-> out_o.prime_factor >= NUM_W'(2) &&
                                       out_o.divisor_sum == '0)
    else $error("malformed factor result");

  // a taken query keeps the block busy for at least the next cycle
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("query accepted while previous one in progress");

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for spf_sieve_divisor_sum, factor and divisor-sum queries
// against an in-bench sieve predictor. Depends on spfds_pkg and the spfds_in_if/out_if channels.
`timescale 1ns / 1ps

module testbench
  import spfds_pkg::*;
();

  localparam int TABLE_SIZE  = 1024;
  localparam int RANDOM_QUERIES = 446;
  localparam int IDLE_LIMIT  = 20000;   // covers the sieve pass after reset with margin
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_WAIT    = 18;

  typedef struct packed {
    logic [NUM_W-1:0] prime_factor;
    logic [SUM_W-1:0] divisor_sum;
    logic             is_last;
  } factor_result_t;

  logic clk_i;
  logic rst_ni;

  spfds_in_if  query_if ();
  spfds_out_if result_if ();

  spf_sieve_divisor_sum #(
    .TABLE_SIZE (TABLE_SIZE)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (query_if),
    .out_o  (result_if)
  );

  // smallest prime factor of every value below the table size
  int unsigned least_prime [TABLE_SIZE];

  logic [NUM_W-1:0] queries_pending [$];
  factor_result_t   factor_results_due [$];

  int unsigned corner_numbers [24] = '{
    0, 1, 2, 3, 4, 1023, 1022, 1021, 512, 768, 960, 961,
    1009, 720, 30, 210, 840, 997, 6, 1000, 1015, 1020, 729, 625
  };

  int  mismatch_count;
  int  idle_cycles;
  bit  query_taken;
  bit  result_taken;
  int  query_gap;
  int  result_gap;
  bit  query_calm;
  int  query_mode_left;
  bit  result_calm;
  int  result_mode_left;

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // sieve of least prime factors, entry 0 holds 0 and entry 1 holds 1
  function automatic void build_sieve();
    int unsigned v;
    int unsigned p;
    int unsigned m;
    for (v = 0; v < TABLE_SIZE; v++) begin
      least_prime[v] = (v >= 2 && v % 2 == 0) ? 2 : v;
    end
    for (p = 3; p * p < TABLE_SIZE; p++) begin
      if (least_prime[p] == p) begin
        for (m = p * p; m < TABLE_SIZE; m += p) begin
          if (least_prime[m] == m) least_prime[m] = p;
        end
      end
    end
  endfunction

  // append one query to the pending list
  function automatic void add_query(input logic [NUM_W-1:0] number);
    queries_pending.insert(queries_pending.size(), number);
  endfunction

  function automatic void push_result(input int unsigned pf, input longint unsigned ds,
                                      input bit last);
    factor_result_t r;
    r.prime_factor = pf[NUM_W-1:0];
    r.divisor_sum  = ds[SUM_W-1:0];
    r.is_last      = last;
    factor_results_due.insert(factor_results_due.size(), r);
  endfunction

  // factors in ascending order, then the product of 1 + p + ... + p^e over the primes
  function automatic void factorize_query(input logic [NUM_W-1:0] number);
    int unsigned       n;
    int unsigned       p;
    int unsigned       cur;
    int                cnt;
    longint unsigned   total;
    longint unsigned   term;
    longint unsigned   power;
    n = number;
    total = 1;
    term = 1;
    power = 1;
    cur = 0;
    cnt = 0;
    if (n >= TABLE_SIZE) begin
      push_result(0, 0, 1'b1);
      return;
    end
    while (n > 1 && cnt < MAX_FACTORS) begin
      p = least_prime[n];
      if (p < 2) break;
      push_result(p, 0, 1'b0);
      cnt++;
      if (p != cur) begin
        total = total * term;
        if (total > SUM_MAX) total = longint'(SUM_MAX) + 1;
        cur = p;
        term = 1;
        power = 1;
      end
      power = power * p;
      term = term + power;
      n = n / p;
    end
    total = total * term;
    if (total > SUM_MAX) total = SUM_MAX;
    push_result(0, total, 1'b1);
  endfunction

  // numbers built from small primes, so queries with many factors come often
  function automatic int unsigned smooth_number();
    int unsigned v;
    int unsigned p;
    int          steps;
    v = 1;
    steps = $urandom_range(1, 10);
    repeat (steps) begin
      case ($urandom_range(0, 6))
        0, 1: p = 2;
        2: p = 3;
        3: p = 5;
        4: p = 7;
        5: p = 11;
        default: p = 31;
      endcase
      if (v * p < TABLE_SIZE) v = v * p;
    end
    return v;
  endfunction

  // wait before the next transfer; runs of calm stretches with no waiting at all
  function automatic int draw_wait(inout bit calm, inout int mode_left);
    if (mode_left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      mode_left = $urandom_range(5, 30);
    end
    mode_left--;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // stimulus, reset and end of run
  initial begin
    int          i;
    int unsigned sel;
    query_if.valid   = 1'b0;
    query_if.number  = '0;
    result_if.ready  = 1'b0;
    rst_ni           = 1'b0;
    mismatch_count   = 0;
    idle_cycles      = 0;
    query_taken      = 1'b0;
    result_taken     = 1'b0;
    query_gap        = 0;
    result_gap       = 0;
    query_mode_left  = 0;
    result_mode_left = 0;
    build_sieve();

    foreach (corner_numbers[k]) add_query(corner_numbers[k][NUM_W-1:0]);
    for (i = 0; i < RANDOM_QUERIES; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        add_query(NUM_W'($urandom_range(0, TABLE_SIZE - 1)));
      end else if (sel < 8) begin
        add_query(NUM_W'(smooth_number()));
      end else if (sel == 8) begin
        add_query(NUM_W'($urandom_range(0, 40)));
      end else begin
        add_query(NUM_W'($urandom_range(TABLE_SIZE - 64, TABLE_SIZE - 1)));
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (queries_pending.size() != 0 || query_if.valid || factor_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (factor_results_due.size() != 0) report_mismatch("results still expected at end");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // monitor: sample both channels, predict on query transfer, check on result transfer
  always @(posedge clk_i) begin
    factor_result_t want;
    query_taken  = rst_ni && query_if.valid && query_if.ready;
    result_taken = rst_ni && result_if.valid && result_if.ready;
    if (query_taken) factorize_query(query_if.number);
    if (result_taken) begin
      if (factor_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result pf=%0d sum=%0d last=%0b",
                                  result_if.prime_factor, result_if.divisor_sum,
                                  result_if.is_last));
      end else begin
        want = factor_results_due.pop_front();
        if (result_if.prime_factor !== want.prime_factor)
          report_mismatch($sformatf("prime_factor %0d, expected %0d",
                                    result_if.prime_factor, want.prime_factor));
        if (result_if.divisor_sum !== want.divisor_sum)
          report_mismatch($sformatf("divisor_sum %0d, expected %0d",
                                    result_if.divisor_sum, want.divisor_sum));
        if (result_if.is_last !== want.is_last)
          report_mismatch($sformatf("is_last %0b, expected %0b",
                                    result_if.is_last, want.is_last));
      end
    end
  end

  // watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (query_taken || result_taken) begin
        idle_cycles <= 0;
      end else if (queries_pending.size() != 0 || query_if.valid ||
                   factor_results_due.size() != 0) begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // query driver: hold an item until its transfer, then wait a drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni && !(query_if.valid && !query_taken)) begin
      if (query_gap > 0) begin
        query_gap <= query_gap - 1;
        query_if.valid <= 1'b0;
      end else if (queries_pending.size() != 0) begin
        query_if.number <= queries_pending.pop_front();
        query_if.valid  <= 1'b1;
        query_gap       <= draw_wait(query_calm, query_mode_left);
      end else begin
        query_if.valid <= 1'b0;
      end
    end
  end

  // result stall: after each transfer draw a stall, counted down while a result is offered
  always @(negedge clk_i) begin
    int gap;
    if (rst_ni) begin
      gap = result_gap;
      if (result_taken) gap = draw_wait(result_calm, result_mode_left);
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        result_gap <= result_if.valid ? gap - 1 : gap;
      end else begin
        result_if.ready <= 1'b1;
        result_gap <= 0;
      end
    end
  end

endmodule
